@@ hw/rtl/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; every other file in hw/rtl refers to this package.
package u8u16_pkg;

   localparam logic [15:0] QMARK         = 16'h003F;
   localparam logic [20:0] CP_MAX        = 21'h10FFFF;
   localparam logic [20:0] SURR_LO       = 21'h00D800;
   localparam logic [20:0] SURR_HI       = 21'h00DFFF;
   localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
   localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
   localparam logic [20:0] SUPP_BASE     = 21'h010000;
   localparam logic [20:0] MIN_THREE     = 21'h000800;
   localparam logic [20:0] MIN_TWO       = 21'h000080;

   // sequence lengths
   localparam logic [2:0] LEN_NONE  = 3'd0;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // depth of the command queue between front and back
   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       string_end;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        replaced;
      logic        run_last;
      logic        string_done;
   } rsp_type;

   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_SINGLE,
      BODY_PAIR
   } body_kind_type;

   // one classified byte: leading '?' run, decoded body, trailing '?' run
   typedef struct packed {
      logic [1:0]    pre_q;
      body_kind_type body;
      logic [15:0]   unit0;
      logic [15:0]   unit1;
      logic          body_rep;
      logic [1:0]    post_q;
      logic          string_end;
   } cmd_type;

endpackage

@@ hw/rtl/u8u16_front.sv @@
// Front end: accepts bytes, tracks the open sequence and classifies each
// byte into one command. Depends on u8u16_pkg.
module u8u16_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  u8u16_pkg::req_type  in_data,
   output u8u16_pkg::cmd_type  cmd
);

   logic [2:0]  exp_len_ff, exp_len_in;
   logic [1:0]  held_ff, held_in;
   logic [20:0] point_ff, point_in;

   logic [7:0]  b;
   logic        seq_open;
   logic        is_cont;
   logic [20:0] point_next;
   logic [2:0]  held_next;
   logic        bad;
   logic [20:0] v;

   assign b        = in_data.data_byte;
   assign seq_open = (exp_len_ff != u8u16_pkg::LEN_NONE);
   assign is_cont  = (b[7:6] == 2'b10);

   assign point_next = {point_ff[14:0], b[5:0]};
   assign held_next  = {1'b0, held_ff} + 3'd1;
   assign v          = point_next - u8u16_pkg::SUPP_BASE;

   // flag overlong, surrogate and out-of-range code points
   always_comb begin
      bad = 1'b0;
      if (exp_len_ff == u8u16_pkg::LEN_TWO && point_next < u8u16_pkg::MIN_TWO) begin
         bad = 1'b1;
      end
      if (exp_len_ff == u8u16_pkg::LEN_THREE && point_next < u8u16_pkg::MIN_THREE) begin
         bad = 1'b1;
      end
      if (exp_len_ff == u8u16_pkg::LEN_FOUR &&
          (point_next < u8u16_pkg::SUPP_BASE || point_next > u8u16_pkg::CP_MAX)) begin
         bad = 1'b1;
      end
      if (point_next >= u8u16_pkg::SURR_LO && point_next <= u8u16_pkg::SURR_HI) begin
         bad = 1'b1;
      end
   end

   // classify the byte and work out the next sequence state
   always_comb begin
      exp_len_in     = exp_len_ff;
      held_in        = held_ff;
      point_in       = point_ff;
      cmd            = '0;
      cmd.body       = u8u16_pkg::BODY_NONE;
      cmd.string_end = in_data.string_end;

      if (seq_open && is_cont) begin
         if (held_next >= exp_len_ff) begin
            // sequence complete
            exp_len_in = u8u16_pkg::LEN_NONE;
            held_in    = 2'd0;
            point_in   = '0;
            if (bad) begin
               cmd.body     = u8u16_pkg::BODY_SINGLE;
               cmd.unit0    = u8u16_pkg::QMARK;
               cmd.body_rep = 1'b1;
            end else if (point_next < u8u16_pkg::SUPP_BASE) begin
               cmd.body  = u8u16_pkg::BODY_SINGLE;
               cmd.unit0 = point_next[15:0];
            end else begin
               cmd.body  = u8u16_pkg::BODY_PAIR;
               cmd.unit0 = u8u16_pkg::HI_SURR_BASE | {6'd0, v[19:10]};
               cmd.unit1 = u8u16_pkg::LO_SURR_BASE | {6'd0, v[9:0]};
            end
         end else if (in_data.string_end) begin
            // string cut short: one '?' per byte of the sequence, this one included
            cmd.post_q = held_next[1:0];
            exp_len_in = u8u16_pkg::LEN_NONE;
            held_in    = 2'd0;
            point_in   = '0;
         end else begin
            held_in  = held_next[1:0];
            point_in = point_next;
         end
      end else begin
         // flush an interrupted sequence, then decode the byte afresh
         if (seq_open) begin
            cmd.pre_q = held_ff;
         end
         exp_len_in = u8u16_pkg::LEN_NONE;
         held_in    = 2'd0;
         point_in   = '0;
         if (b inside {[8'h00:8'h7F]}) begin
            cmd.body  = u8u16_pkg::BODY_SINGLE;
            cmd.unit0 = {8'd0, b};
         end else if (b inside {[8'h80:8'hBF], [8'hF8:8'hFF]}) begin
            cmd.body     = u8u16_pkg::BODY_SINGLE;
            cmd.unit0    = u8u16_pkg::QMARK;
            cmd.body_rep = 1'b1;
         end else if (in_data.string_end) begin
            cmd.post_q = 2'd1;
         end else begin
            held_in = 2'd1;
            if (b inside {[8'hC0:8'hDF]}) begin
               exp_len_in = u8u16_pkg::LEN_TWO;
               point_in   = {16'd0, b[4:0]};
            end else if (b inside {[8'hE0:8'hEF]}) begin
               exp_len_in = u8u16_pkg::LEN_THREE;
               point_in   = {17'd0, b[3:0]};
            end else begin
               exp_len_in = u8u16_pkg::LEN_FOUR;
               point_in   = {18'd0, b[2:0]};
            end
         end
      end
   end

   // advance the sequence state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= u8u16_pkg::LEN_NONE;
         held_ff    <= 2'd0;
         point_ff   <= '0;
      end else if (in_valid) begin
         exp_len_ff <= exp_len_in;
         held_ff    <= held_in;
         point_ff   <= point_in;
      end
   end

endmodule

@@ hw/rtl/u8u16_cmd_fifo.sv @@
// Short command queue between the front and back ends.
// Depends on u8u16_pkg for the command type and depth.
module u8u16_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8u16_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output u8u16_pkg::cmd_type pop_data,
   output logic               empty
);

   u8u16_pkg::cmd_type entries_ff [u8u16_pkg::CMD_DEPTH];

   logic [u8u16_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8u16_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u8u16_pkg::CMD_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == u8u16_pkg::CMD_CNT_W'(u8u16_pkg::CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + u8u16_pkg::CMD_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + u8u16_pkg::CMD_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + u8u16_pkg::CMD_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - u8u16_pkg::CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the entry on each transfer
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/u8u16_back.sv @@
// Back end: writes each command's code units to the result register,
// one per cycle while that register is free. Depends on u8u16_pkg.
module u8u16_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_empty,
   input  u8u16_pkg::cmd_type cmd,
   output logic               cmd_pop,
   output logic               out_valid,
   output u8u16_pkg::rsp_type out_data,
   input  logic               out_pop
);

   logic [1:0]         pos_ff, pos_in;
   logic               valid_ff, valid_in;
   u8u16_pkg::rsp_type data_ff, data_in;

   logic [2:0] body_cnt;
   logic [3:0] total;
   logic [2:0] rel;
   logic       in_pre;
   logic       in_body;
   logic       is_last;
   logic       slot_free;

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign slot_free = !valid_ff || out_pop;

   // locate the current unit within the command
   always_comb begin
      case (cmd.body)
         u8u16_pkg::BODY_SINGLE: body_cnt = 3'd1;
         u8u16_pkg::BODY_PAIR:   body_cnt = 3'd2;
         default:                body_cnt = 3'd0;
      endcase
      total   = {2'd0, cmd.pre_q} + {1'b0, body_cnt} + {2'd0, cmd.post_q};
      rel     = {1'b0, pos_ff} - {1'b0, cmd.pre_q};
      in_pre  = (pos_ff < cmd.pre_q);
      in_body = !in_pre && (rel < body_cnt);
      is_last = ({2'd0, pos_ff} + 4'd1 == total);
   end

   // emit units, drop commands that carry none
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff && !out_pop;
      data_in  = data_ff;
      cmd_pop  = 1'b0;
      if (!cmd_empty) begin
         if (total == 4'd0) begin
            cmd_pop = 1'b1;
         end else if (slot_free) begin
            valid_in = 1'b1;
            if (in_body) begin
               data_in.code_unit = (rel == 3'd0) ? cmd.unit0 : cmd.unit1;
               data_in.replaced  = cmd.body_rep;
            end else begin
               data_in.code_unit = u8u16_pkg::QMARK;
               data_in.replaced  = 1'b1;
            end
            data_in.run_last    = is_last;
            data_in.string_done = is_last && cmd.string_end;
            if (is_last) begin
               cmd_pop = 1'b1;
               pos_in  = 2'd0;
            end else begin
               pos_in = pos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // hold the result payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ hw/rtl/utf8_to_utf16_transcoder_unit.sv @@
// UTF-8 to UTF-16 transcoder, top level: front end, command queue, back end.
// Throughput: one byte per cycle while each byte gives at most one unit and
// results are popped; the back end emits one unit per cycle while its result
// register is free, so multi-unit bytes fill the queue.
// Reset is synchronous and clears sequence state, queue and result register.
module utf8_to_utf16_transcoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  u8u16_pkg::req_type req_data,
   output logic               req_full,
   input  logic               rsp_pop,
   output u8u16_pkg::rsp_type rsp_data,
   output logic               rsp_empty
);

   u8u16_pkg::cmd_type front_cmd;
   u8u16_pkg::cmd_type head_cmd;
   logic               cmd_push;
   logic               cmd_pop;
   logic               cmd_empty;
   logic               out_valid;

   assign cmd_push  = req_push && !req_full;
   assign rsp_empty = !out_valid;

   u8u16_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(cmd_push),
      .in_data (req_data),
      .cmd     (front_cmd)
   );

   u8u16_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(front_cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .pop_data (head_cmd),
      .empty    (cmd_empty)
   );

   u8u16_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd      (head_cmd),
      .cmd_pop  (cmd_pop),
      .out_valid(out_valid),
      .out_data (rsp_data),
      .out_pop  (rsp_pop)
   );

   // reset leaves both sides idle
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("not idle after reset");

   // never take a command from an empty queue
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !cmd_empty)
      else $error("command taken from empty queue");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("stalled result changed");

endmodule
